// ===== src/dpab_pkg.sv =====
// ----------------------------------------------------------------------------
// dpab_pkg: shared types and constants for the data-processing ALU
// Instruction field positions, opcode and shift codes, flag and result types.
// ----------------------------------------------------------------------------
package dpab_pkg;

	localparam int DATA_W    = 32;
	localparam int REG_COUNT = 16;
	localparam int REG_AW    = $clog2(REG_COUNT);

	// instruction field positions
	localparam int BIT_IMM       = 25;
	localparam int OPC_LSB       = 21;
	localparam int BIT_SET_FLAGS = 20;
	localparam int RN_LSB        = 16;
	localparam int RD_LSB        = 12;
	localparam int RS_LSB        = 8;
	localparam int ROT_LSB       = 8;
	localparam int SHAMT_LSB     = 7;
	localparam int STYPE_LSB     = 5;
	localparam int BIT_REG_SHIFT = 4;
	localparam int RM_LSB        = 0;
	localparam int IMM_W         = 8;
	localparam int SHAMT_W       = 5;

	typedef enum logic [3:0] {
		OP_AND = 4'd0,
		OP_EOR = 4'd1,
		OP_SUB = 4'd2,
		OP_RSB = 4'd3,
		OP_ADD = 4'd4,
		OP_TST = 4'd8,
		OP_TEQ = 4'd9,
		OP_CMP = 4'd10,
		OP_ORR = 4'd12,
		OP_MOV = 4'd13
	} opcode_t;

	typedef enum logic [1:0] {
		SH_LSL = 2'd0,
		SH_LSR = 2'd1,
		SH_ASR = 2'd2,
		SH_ROR = 2'd3
	} shift_t;

	typedef enum logic {
		CMD_EXEC = 1'b0,
		CMD_LOAD = 1'b1
	} cmd_t;

	typedef struct packed {
		logic n;
		logic z;
		logic c;
		logic v;
	} flags_t;

	typedef struct packed {
		logic [DATA_W-1:0] result;
		logic [REG_AW-1:0] dest;
		logic              wr_en;
		flags_t            flags;
		logic              bad;
	} exec_t;

	function automatic logic [DATA_W-1:0] ror32(input logic [DATA_W-1:0] v,
			input logic [SHAMT_W-1:0] k);
		logic [2*DATA_W-1:0] t;
		t = {v, v} >> k;
		return t[DATA_W-1:0];
	endfunction

endpackage

// ===== src/dpab_ram.sv =====
// ----------------------------------------------------------------------------
// dpab_ram: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dpab_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== src/dpab_exec.sv =====
// ----------------------------------------------------------------------------
// dpab_exec: operand shifter and ALU
// Builds the second operand, runs the operation and forms the new flags.
// ----------------------------------------------------------------------------
module dpab_exec (
	input  logic                               command,
	input  logic [dpab_pkg::DATA_W-1:0]        instruction,
	input  logic [dpab_pkg::REG_AW-1:0]        load_index,
	input  logic [dpab_pkg::DATA_W-1:0]        load_value,
	input  logic [dpab_pkg::DATA_W-1:0]        rn_val,
	input  logic [dpab_pkg::DATA_W-1:0]        rm_val,
	input  logic [dpab_pkg::DATA_W-1:0]        rs_val,
	input  dpab_pkg::flags_t                   flags_in,
	output dpab_pkg::exec_t                    ex
);
	import dpab_pkg::*;

	localparam int AMT_W = 8;

	opcode_t             opc;
	shift_t              stype;
	logic [AMT_W-1:0]    amt;
	logic [5:0]          amt_c;
	logic                amt_big;
	logic [DATA_W:0]     t_lsl;
	logic [DATA_W:0]     t_lsr;
	logic [DATA_W:0]     t_asr;
	logic [DATA_W-1:0]   rot_v;
	logic [SHAMT_W-1:0]  imm_k;
	logic [DATA_W-1:0]   imm_rot;
	logic [DATA_W-1:0]   op2;
	logic                sc;
	logic [DATA_W-1:0]   add_a;
	logic [DATA_W-1:0]   add_b;
	logic                add_ci;
	logic [DATA_W:0]     sum;
	logic [DATA_W-1:0]   res;
	logic                c_out;
	logic                writes;
	logic                bad;

	// second operand
	always_comb begin
		stype   = shift_t'(instruction[STYPE_LSB +: 2]);
		amt     = instruction[BIT_REG_SHIFT] ? rs_val[AMT_W-1:0]
			: {{(AMT_W-SHAMT_W){1'b0}}, instruction[SHAMT_LSB +: SHAMT_W]};
		amt_big = amt > AMT_W'(DATA_W);
		amt_c   = amt_big ? 6'(DATA_W) : amt[5:0];
		t_lsl   = {1'b0, rm_val} << amt_c;
		t_lsr   = {rm_val, 1'b0} >> amt_c;
		t_asr   = (DATA_W+1)'($signed({rm_val, 1'b0}) >>> amt_c);
		rot_v   = ror32(rm_val, amt[SHAMT_W-1:0]);
		imm_k   = {instruction[ROT_LSB +: 4], 1'b0};
		imm_rot = ror32({{(DATA_W-IMM_W){1'b0}}, instruction[IMM_W-1:0]}, imm_k);
		op2     = rm_val;
		sc      = flags_in.c;
		if (instruction[BIT_IMM]) begin
			op2 = imm_rot;
			sc  = (imm_k == '0) ? flags_in.c : imm_rot[DATA_W-1];
		end else if (amt != '0) begin
			unique case (stype)
				SH_LSL: begin
					op2 = amt_big ? '0 : t_lsl[DATA_W-1:0];
					sc  = amt_big ? 1'b0 : t_lsl[DATA_W];
				end
				SH_LSR: begin
					op2 = amt_big ? '0 : t_lsr[DATA_W:1];
					sc  = amt_big ? 1'b0 : t_lsr[0];
				end
				SH_ASR: begin
					op2 = t_asr[DATA_W:1];
					sc  = t_asr[0];
				end
				SH_ROR: begin
					op2 = rot_v;
					sc  = rot_v[DATA_W-1];
				end
				default: begin
					op2 = rm_val;
					sc  = flags_in.c;
				end
			endcase
		end
	end

	// operation
	always_comb begin
		opc    = opcode_t'(instruction[OPC_LSB +: 4]);
		add_a  = rn_val;
		add_b  = ~op2;
		add_ci = 1'b1;
		if (opc == OP_RSB) begin
			add_a = op2;
			add_b = ~rn_val;
		end else if (opc == OP_ADD) begin
			add_b  = op2;
			add_ci = 1'b0;
		end
		sum    = {1'b0, add_a} + {1'b0, add_b} + (DATA_W+1)'(add_ci);
		res    = '0;
		c_out  = sc;
		writes = 1'b1;
		bad    = 1'b0;
		unique case (opc)
			OP_AND: res = rn_val & op2;
			OP_EOR: res = rn_val ^ op2;
			OP_SUB, OP_RSB, OP_ADD: begin
				res   = sum[DATA_W-1:0];
				c_out = sum[DATA_W];
			end
			OP_TST: begin
				res    = rn_val & op2;
				writes = 1'b0;
			end
			OP_TEQ: begin
				res    = rn_val ^ op2;
				writes = 1'b0;
			end
			OP_CMP: begin
				res    = sum[DATA_W-1:0];
				c_out  = sum[DATA_W];
				writes = 1'b0;
			end
			OP_ORR: res = rn_val | op2;
			OP_MOV: res = op2;
			default: begin
				bad    = 1'b1;
				writes = 1'b0;
			end
		endcase
	end

	always_comb begin
		if (cmd_t'(command) == CMD_LOAD) begin
			ex.result = load_value;
			ex.dest   = load_index;
			ex.wr_en  = 1'b1;
			ex.flags  = flags_in;
			ex.bad    = 1'b0;
		end else begin
			ex.result = res;
			ex.dest   = writes ? instruction[RD_LSB +: REG_AW] : '0;
			ex.wr_en  = writes;
			ex.bad    = bad;
			ex.flags  = flags_in;
			if (!bad && instruction[BIT_SET_FLAGS]) begin
				ex.flags.n = res[DATA_W-1];
				ex.flags.z = (res == '0);
				ex.flags.c = c_out;
			end
		end
	end

endmodule

// ===== src/dataproc_alu_barrel_shift_unit.sv =====
// ----------------------------------------------------------------------------
// dataproc_alu_barrel_shift_unit: data-processing ALU with barrel shifter
// Executes one instruction or register load per beat on a 16 x 32 register file.
// ----------------------------------------------------------------------------
//
//  channel  handshake               payload
//  -------  ----------------------  ---------------------------------------------
//  in       in_valid / in_stall     command, instruction, load_index, load_value
//  out      out_valid / out_stall   alu_result, dest_index, dest_written,
//                                   flag_n, flag_z, flag_c, flag_v, bad_opcode
//
//  One beat per cycle unless the output stalls; beats pass execute and result regs.
//  Register file reads happen on the input beat (three RAM copies, one per
//  operand); execute stage forwards the write made on the same edge.
//  Reset clears the register file through per-entry valid bits, and the flags.
//  A stalled output holds the execute stage, which then stalls the input.
//
module dataproc_alu_barrel_shift_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           command,
	input  logic [dpab_pkg::DATA_W-1:0]    instruction,
	input  logic [dpab_pkg::REG_AW-1:0]    load_index,
	input  logic [dpab_pkg::DATA_W-1:0]    load_value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [dpab_pkg::DATA_W-1:0]    alu_result,
	output logic [dpab_pkg::REG_AW-1:0]    dest_index,
	output logic                           dest_written,
	output logic                           flag_n,
	output logic                           flag_z,
	output logic                           flag_c,
	output logic                           flag_v,
	output logic                           bad_opcode
);
	import dpab_pkg::*;

	logic                  in_acc;
	logic                  s1_adv;
	logic                  s1_valid_q;
	logic                  out_valid_q;

	logic                  cmd_s1;
	logic [DATA_W-1:0]     inst_s1;
	logic [REG_AW-1:0]     lidx_s1;
	logic [DATA_W-1:0]     lval_s1;
	logic                  rn_ok_s1;
	logic                  rm_ok_s1;
	logic                  rs_ok_s1;

	logic [DATA_W-1:0]     rn_ram;
	logic [DATA_W-1:0]     rm_ram;
	logic [DATA_W-1:0]     rs_ram;
	logic [DATA_W-1:0]     rn_val;
	logic [DATA_W-1:0]     rm_val;
	logic [DATA_W-1:0]     rs_val;

	logic [REG_COUNT-1:0]  reg_ok_q;
	logic                  byp_en_q;
	logic [REG_AW-1:0]     byp_idx_q;
	logic [DATA_W-1:0]     byp_val_q;
	flags_t                flags_q;

	exec_t                 ex;
	exec_t                 res_s2;
	logic                  wr_en;

	assign in_acc   = in_valid && !in_stall;
	assign s1_adv   = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid_q && out_valid_q && out_stall;
	assign wr_en    = s1_adv && ex.wr_en;

	// register file copies, one per read operand
	dpab_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_ram_rn (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (ex.dest),
		.wr_data (ex.result),
		.rd_en   (in_acc),
		.rd_addr (instruction[RN_LSB +: REG_AW]),
		.rd_data (rn_ram)
	);

	dpab_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_ram_rm (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (ex.dest),
		.wr_data (ex.result),
		.rd_en   (in_acc),
		.rd_addr (instruction[RM_LSB +: REG_AW]),
		.rd_data (rm_ram)
	);

	dpab_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_ram_rs (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (ex.dest),
		.wr_data (ex.result),
		.rd_en   (in_acc),
		.rd_addr (instruction[RS_LSB +: REG_AW]),
		.rd_data (rs_ram)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			reg_ok_q    <= '0;
			byp_en_q    <= 1'b0;
			flags_q     <= '0;
		end else begin
			if (in_acc) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
				byp_en_q    <= ex.wr_en;
				flags_q     <= ex.flags;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (wr_en) begin
				reg_ok_q[ex.dest] <= 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1   <= command;
			inst_s1  <= instruction;
			lidx_s1  <= load_index;
			lval_s1  <= load_value;
			rn_ok_s1 <= reg_ok_q[instruction[RN_LSB +: REG_AW]];
			rm_ok_s1 <= reg_ok_q[instruction[RM_LSB +: REG_AW]];
			rs_ok_s1 <= reg_ok_q[instruction[RS_LSB +: REG_AW]];
		end
		if (s1_adv) begin
			res_s2    <= ex;
			byp_idx_q <= ex.dest;
			byp_val_q <= ex.result;
		end
	end

	// forward the write that landed on the same edge as the read
	always_comb begin
		rn_val = rn_ok_s1 ? rn_ram : '0;
		rm_val = rm_ok_s1 ? rm_ram : '0;
		rs_val = rs_ok_s1 ? rs_ram : '0;
		if (byp_en_q && byp_idx_q == inst_s1[RN_LSB +: REG_AW]) begin
			rn_val = byp_val_q;
		end
		if (byp_en_q && byp_idx_q == inst_s1[RM_LSB +: REG_AW]) begin
			rm_val = byp_val_q;
		end
		if (byp_en_q && byp_idx_q == inst_s1[RS_LSB +: REG_AW]) begin
			rs_val = byp_val_q;
		end
	end

	dpab_exec u_exec (
		.command     (cmd_s1),
		.instruction (inst_s1),
		.load_index  (lidx_s1),
		.load_value  (lval_s1),
		.rn_val      (rn_val),
		.rm_val      (rm_val),
		.rs_val      (rs_val),
		.flags_in    (flags_q),
		.ex          (ex)
	);

	assign out_valid    = out_valid_q;
	assign alu_result   = res_s2.result;
	assign dest_index   = res_s2.dest;
	assign dest_written = res_s2.wr_en;
	assign flag_n       = res_s2.flags.n;
	assign flag_z       = res_s2.flags.z;
	assign flag_c       = res_s2.flags.c;
	assign flag_v       = res_s2.flags.v;
	assign bad_opcode   = res_s2.bad;

`ifndef SYNTHESIS
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> s1_valid_q)
		else $error("accepted beat did not reach the execute stage");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (s1_valid_q && out_valid_q && out_stall))
		else $error("input stalled while the pipeline could move");

	a_bad_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && ex.bad) |-> (!ex.wr_en && ex.flags == flags_q))
		else $error("unknown opcode changed architectural state");

	a_v_held: assert property (@(posedge clk) disable iff (!arst_n)
		!flags_q.v)
		else $error("overflow flag changed");
`endif

endmodule
